[sv/spru_pkg.sv]
// Shared types, status and op codes, and a byte swap helper for the sprite pixel run unpacker.
// No dependencies.
package spru_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_FEED  = 2'd1;
    localparam logic [1:0] OP_PEN   = 2'd2;

    localparam logic [2:0] ST_PEN          = 3'd0;
    localparam logic [2:0] ST_DATA_NEEDED  = 3'd1;
    localparam logic [2:0] ST_END_LINE     = 3'd2;
    localparam logic [2:0] ST_END_SPRITE   = 3'd3;
    localparam logic [2:0] ST_END_QUADRANT = 3'd4;
    localparam logic [2:0] ST_LINE_STARTED = 3'd5;
    localparam logic [2:0] ST_ACCEPTED     = 3'd6;
    localparam logic [2:0] ST_OVERFLOW     = 3'd7;

    localparam logic REG_BITS_PER_PEN = 1'b0;
    localparam logic REG_LITERAL_MODE = 1'b1;

    localparam logic [2:0] BPP_RESET   = 3'd4;
    localparam logic [3:0] HEADER_BITS = 4'd5;
    localparam logic [6:0] WORD_BITS   = 7'd32;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] pen;
        logic [7:0] line_offset;
    } t_out_item;

    typedef struct packed {
        logic [2:0] bits_per_pen;
        logic       literal_mode;
    } t_cfg;

    // byte 0 of the word goes to the top so it is read first
    function automatic logic [31:0] swap_bytes(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

[sv/spru_core.sv]
// Decoder state and step logic of the sprite pixel run unpacker.
// Depends on spru_pkg.
module spru_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  spru_pkg::t_in_item i_item,
    input  spru_pkg::t_cfg     i_cfg,
    output spru_pkg::t_out_item o_result
);

    logic [63:0] r_shifter, n_shifter;
    logic [6:0]  r_bb, n_bb;
    logic [10:0] r_lbl, n_lbl;
    logic [7:0]  r_offset, n_offset;
    logic        r_ril, n_ril;
    logic [3:0]  r_rr, n_rr;
    logic [3:0]  r_last, n_last;

    logic [2:0]  bpp;
    logic [72:0] ext;
    logic [8:0]  win;
    logic [31:0] swapped;
    logic        hdr_due;
    logic        repeat_run;
    logic [3:0]  need;
    logic [3:0]  pen;
    logic [2:0]  status;

    always_comb begin
        if (i_cfg.bits_per_pen == 3'd0) begin
            bpp = 3'd1;
        end else if (i_cfg.bits_per_pen > 3'd4) begin
            bpp = 3'd4;
        end else begin
            bpp = i_cfg.bits_per_pen;
        end
    end

    assign ext        = {r_shifter, 9'b0};
    assign win        = ext[r_bb +: 9];
    assign swapped    = spru_pkg::swap_bytes(i_item.data_word);
    assign repeat_run = !i_cfg.literal_mode && !r_ril && (r_rr != 4'd0);
    assign hdr_due    = !(i_cfg.literal_mode || (r_ril && (r_rr != 4'd0)));
    assign need       = {1'b0, bpp} + (hdr_due ? spru_pkg::HEADER_BITS : 4'd0);

    always_comb begin
        n_shifter = r_shifter;
        n_bb      = r_bb;
        n_lbl     = r_lbl;
        n_offset  = r_offset;
        n_ril     = r_ril;
        n_rr      = r_rr;
        n_last    = r_last;
        pen       = 4'd0;
        status    = spru_pkg::ST_ACCEPTED;
        case (i_item.op)
            spru_pkg::OP_START: begin
                n_shifter = {32'b0, swapped};
                n_bb      = 7'd24;
                n_offset  = i_item.data_word[7:0];
                n_ril     = 1'b0;
                n_rr      = 4'd0;
                if (i_item.data_word[7:0] == 8'd0) begin
                    n_lbl  = 11'd0;
                    status = spru_pkg::ST_END_SPRITE;
                end else if (i_item.data_word[7:0] == 8'd1) begin
                    n_lbl  = 11'd0;
                    status = spru_pkg::ST_END_QUADRANT;
                end else begin
                    n_lbl  = {i_item.data_word[7:0] - 8'd1, 3'b000};
                    status = spru_pkg::ST_LINE_STARTED;
                end
            end
            spru_pkg::OP_FEED: begin
                if (r_bb > spru_pkg::WORD_BITS) begin
                    status = spru_pkg::ST_OVERFLOW;
                end else begin
                    n_shifter = {r_shifter[31:0], swapped};
                    n_bb      = r_bb + spru_pkg::WORD_BITS;
                end
            end
            spru_pkg::OP_PEN: begin
                if (repeat_run) begin
                    n_rr   = r_rr - 4'd1;
                    pen    = r_last;
                    status = spru_pkg::ST_PEN;
                end else if (r_lbl <= {7'b0, need}) begin
                    n_shifter = 64'd0;
                    n_bb      = 7'd0;
                    n_ril     = 1'b0;
                    n_rr      = 4'd0;
                    status    = spru_pkg::ST_END_LINE;
                end else if (r_bb < {3'b0, need}) begin
                    status = spru_pkg::ST_DATA_NEEDED;
                end else if (hdr_due) begin
                    if (!win[8] && (win[7:4] == 4'd0)) begin
                        n_lbl     = 11'd0;
                        n_shifter = 64'd0;
                        n_bb      = 7'd0;
                        n_ril     = 1'b0;
                        n_rr      = 4'd0;
                        status    = spru_pkg::ST_END_LINE;
                    end else begin
                        n_ril  = win[8];
                        n_rr   = win[7:4];
                        pen    = win[3:0] >> (3'd4 - bpp);
                        n_last = pen;
                        n_bb   = r_bb - {3'b0, need};
                        n_lbl  = r_lbl - {7'b0, need};
                        status = spru_pkg::ST_PEN;
                    end
                end else begin
                    pen    = win[8:5] >> (3'd4 - bpp);
                    n_last = pen;
                    n_bb   = r_bb - {4'b0, bpp};
                    n_lbl  = r_lbl - {8'b0, bpp};
                    if (!i_cfg.literal_mode) begin
                        n_rr = r_rr - 4'd1;
                    end
                    status = spru_pkg::ST_PEN;
                end
            end
            default: begin
                status = spru_pkg::ST_ACCEPTED;
            end
        endcase
    end

    assign o_result.status      = status;
    assign o_result.pen         = pen;
    assign o_result.line_offset = n_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shifter <= 64'd0;
            r_bb      <= 7'd0;
            r_lbl     <= 11'd0;
            r_offset  <= 8'd0;
            r_ril     <= 1'b0;
            r_rr      <= 4'd0;
            r_last    <= 4'd0;
        end else if (i_fire) begin
            r_shifter <= n_shifter;
            r_bb      <= n_bb;
            r_lbl     <= n_lbl;
            r_offset  <= n_offset;
            r_ril     <= n_ril;
            r_rr      <= n_rr;
            r_last    <= n_last;
        end
    end

endmodule

[sv/sprite_pixel_run_unpacker.sv]
// Top level of the sprite pixel run unpacker: input register, config registers,
// result register and checks. Depends on spru_pkg and spru_core.

// Takes one item per clock while results are taken and returns exactly one result
// item for each. An item sits in the input register while the decoder core works on
// it against the line state, and its result is then registered in the result register.
// Throughput is one item per cycle while results are taken, as the decoder core
// updates its state once per item. While a result waits to be taken, the input register
// holds one more item and then input ready stays low until the result leaves.
// Configuration registers reset to 4 bits per pen and packed mode.
module sprite_pixel_run_unpacker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  spru_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spru_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [2:0]          i_cfg_wdata
);

    logic                r_in_valid;
    spru_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    spru_pkg::t_out_item r_out_item;
    spru_pkg::t_cfg      r_cfg;
    spru_pkg::t_out_item result;
    logic                fire;
    logic                in_take;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bits_per_pen <= spru_pkg::BPP_RESET;
            r_cfg.literal_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spru_pkg::REG_BITS_PER_PEN: r_cfg.bits_per_pen <= i_cfg_wdata;
                spru_pkg::REG_LITERAL_MODE: r_cfg.literal_mode <= i_cfg_wdata[0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    spru_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("decoded item produced no result");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid)
        else $error("waiting item lost from input register");

    a_pen_zero_otherwise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != spru_pkg::ST_PEN) |-> o_out_item.pen == 4'd0)
        else $error("pen nonzero on non-pen status");

    a_sprite_end_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == spru_pkg::ST_END_SPRITE)
        |-> o_out_item.line_offset == 8'd0)
        else $error("end of sprite with nonzero offset");
`endif

endmodule
